// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top level of the quaternion to Euler block.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define Q2E_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define Q2E_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/q2e_pkg.sv =====
// Shared types and constants of the quaternion to Euler block.
// Used by the CORDIC cells, the CORDIC chain, the square root cells and the top level.
package q2e_pkg;

	localparam int ZW = 33;
	localparam int TAB_LEN = 24;
	localparam int SQ_STAGES = 31;
	localparam int SQ_W = 62;
	localparam int A_W = 30;
	localparam int PITCH_LIM = 12868;
	localparam int ANGLE_LIM = 25736;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 33'sd1686629713;

	typedef logic signed [15:0] angle_t;

	typedef struct packed {
		logic clamp;
		logic neg;
	} pflag_t;

	// atan(2^-i) in radians, Q.30, rounded.
	function automatic logic signed [ZW-1:0] atan_entry(input int idx);
		logic signed [ZW-1:0] v;
		case (idx)
			0: v = 33'sd843314857;
			1: v = 33'sd497837829;
			2: v = 33'sd263043837;
			3: v = 33'sd133525159;
			4: v = 33'sd67021687;
			5: v = 33'sd33543516;
			6: v = 33'sd16775851;
			7: v = 33'sd8388437;
			8: v = 33'sd4194283;
			9: v = 33'sd2097149;
			10: v = 33'sd1048576;
			11: v = 33'sd524288;
			12: v = 33'sd262144;
			13: v = 33'sd131072;
			14: v = 33'sd65536;
			15: v = 33'sd32768;
			16: v = 33'sd16384;
			17: v = 33'sd8192;
			18: v = 33'sd4096;
			19: v = 33'sd2048;
			20: v = 33'sd1024;
			21: v = 33'sd512;
			22: v = 33'sd256;
			23: v = 33'sd128;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== hdl/q2e_cordic_cell.sv =====
// One vectoring CORDIC iteration with its output register.
// Depends on q2e_pkg for the arctangent table.
module q2e_cordic_cell import q2e_pkg::*; #(
	parameter int W = 37,
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [W-1:0]  x,
	input  logic signed [W-1:0]  y,
	input  logic signed [ZW-1:0] z,
	input  logic                 zero,
	output logic signed [W-1:0]  x_q,
	output logic signed [W-1:0]  y_q,
	output logic signed [ZW-1:0] z_q,
	output logic                 zero_q
);

	logic signed [W-1:0] dx;
	logic signed [W-1:0] dy;

	assign dx = y >>> IDX;
	assign dy = x >>> IDX;

	always_ff @(posedge clk) begin
		if (en) begin
			zero_q <= zero;
			if (y >= 0) begin
				x_q <= x + dx;
				y_q <= y - dy;
				z_q <= z + atan_entry(IDX);
			end else begin
				x_q <= x - dx;
				y_q <= y + dy;
				z_q <= z - atan_entry(IDX);
			end
		end
	end

endmodule

// ===== hdl/q2e_sqrt_cell.sv =====
// One digit of the integer square root, with its output register.
// Depends on q2e_pkg for the word width.
module q2e_sqrt_cell import q2e_pkg::*; #(
	parameter int K = 30
) (
	input  logic            clk,
	input  logic            en,
	input  logic [SQ_W-1:0] v,
	input  logic [SQ_W-1:0] res,
	output logic [SQ_W-1:0] v_q,
	output logic [SQ_W-1:0] res_q
);

	localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * K);

	logic [SQ_W-1:0] trial;

	assign trial = res + BIT;

	always_ff @(posedge clk) begin
		if (en) begin
			if (v >= trial) begin
				v_q   <= v - trial;
				res_q <= (res >> 1) + BIT;
			end else begin
				v_q   <= v;
				res_q <= res >> 1;
			end
		end
	end

endmodule

// ===== hdl/q2e_cordic_chain.sv =====
// atan2 as a row of CORDIC cells: quadrant pre-rotation, the cells, and the
// conversion of the Q.30 angle to saturated Q3.13. Depends on q2e_pkg and q2e_cordic_cell.
module q2e_cordic_chain import q2e_pkg::*; #(
	parameter int W = 37,
	parameter int STAGES = 16,
	parameter int LIM = 25736
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] x_in,
	input  logic signed [W-1:0] y_in,
	output angle_t              angle
);

	localparam int RW = ZW - 16;
	localparam logic signed [RW-1:0] LIM_P = RW'(LIM);

	logic signed [W-1:0]  x_s [STAGES+1];
	logic signed [W-1:0]  y_s [STAGES+1];
	logic signed [ZW-1:0] z_s [STAGES+1];
	logic                 zero_s [STAGES+1];
	logic signed [ZW:0]   zr;
	logic signed [RW-1:0] r;
	angle_t               sat;
	angle_t               angle_q;

	// A vector in the left half plane is turned by a quarter turn first.
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				if (y_in >= 0) begin
					x_s[0] <= y_in;
					y_s[0] <= -x_in;
					z_s[0] <= HALF_PI_Q30;
				end else begin
					x_s[0] <= -y_in;
					y_s[0] <= x_in;
					z_s[0] <= -HALF_PI_Q30;
				end
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_cell
		q2e_cordic_cell #(.W(W), .IDX(i)) u_cell (
			.clk    (clk),
			.en     (en),
			.x      (x_s[i]),
			.y      (y_s[i]),
			.z      (z_s[i]),
			.zero   (zero_s[i]),
			.x_q    (x_s[i+1]),
			.y_q    (y_s[i+1]),
			.z_q    (z_s[i+1]),
			.zero_q (zero_s[i+1])
		);
	end

	// Round half up to 13 fraction bits, then saturate.
	always_comb begin
		zr = (ZW+1)'(z_s[STAGES]) + (ZW+1)'(65536);
		r  = RW'(zr >>> 17);
		if (r > LIM_P) begin
			sat = 16'(LIM_P);
		end else if (r < -LIM_P) begin
			sat = 16'(-LIM_P);
		end else begin
			sat = 16'(r);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_q <= zero_s[STAGES] ? '0 : sat;
		end
	end

	assign angle = angle_q;

endmodule

// ===== hdl/quaternion_to_euler_top.sv =====
// Quaternion (Q2.14) to roll and yaw (Q3.13) and pitch (Q2.13), ZYX convention.
// One item is accepted every cycle unless a stalled result holds the pipeline. The pitch
// path sets the latency: 31 square root cells plus its CORDIC row.
// A stalled result freezes the whole pipeline. arst_n clears the valid bits only.
// Depends on q2e_pkg, q2e_cordic_chain, q2e_sqrt_cell and assert_macros.svh.
`include "assert_macros.svh"

module quaternion_to_euler_top import q2e_pkg::*; #(
	parameter int CORDIC_STAGES = 16,
	parameter int IN_FRAC_BITS = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               quat_valid,
	output logic               quat_stall,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	output logic               euler_valid,
	input  logic               euler_stall,
	output logic signed [15:0] roll_angle,
	output logic signed [14:0] pitch_angle,
	output logic signed [15:0] yaw_angle,
	output logic               pitch_clamped
);

	localparam int MW = (2 * IN_FRAC_BITS > 33) ? 2 * IN_FRAC_BITS : 33;
	localparam int CW = MW + 4;
	localparam int PW = 34;
	localparam int SH = 2 * IN_FRAC_BITS - 30;
	localparam int RD = SQ_STAGES + 3;
	localparam int FD = SQ_STAGES + CORDIC_STAGES + 4;
	localparam int AD = SQ_STAGES + 2;
	localparam int LAT = SQ_STAGES + CORDIC_STAGES + 8;
	localparam logic signed [CW-1:0] ONE = CW'(1) <<< (2 * IN_FRAC_BITS);
	localparam logic [SQ_W-1:0] ONE_Q60 = SQ_W'(1) << 60;

	logic en;
	logic [LAT-1:0] vld_q;

	logic signed [31:0] p_wx_s1, p_yz_s1, p_xx_s1, p_yy_s1, p_wz_s1;
	logic signed [31:0] p_xy_s1, p_zz_s1, p_wy_s1, p_zx_s1;
	logic signed [CW-1:0] sr_s2, cr_s2, sy_s2, cy_s2, s_s2;
	logic [CW-1:0] a_mag;
	logic [A_W-1:0] a30;
	pflag_t flag_s3;
	logic [A_W-1:0] a30_s3;
	logic [2*A_W-1:0] sq_s4;
	logic [SQ_W-1:0] rad_s5;
	logic [A_W-1:0] ad_q [AD];
	logic [SQ_W-1:0] sq_v [SQ_STAGES+1];
	logic [SQ_W-1:0] sq_r [SQ_STAGES+1];
	logic signed [PW-1:0] px, py;
	angle_t roll_c, yaw_c, pitch_c;
	angle_t roll_dly_q [RD];
	angle_t yaw_dly_q [RD];
	pflag_t flag_dly_q [FD];
	angle_t pitch_v;
	angle_t roll_q, yaw_q;
	logic signed [14:0] pitch_q;
	logic clamp_q;

	assign en = !(vld_q[LAT-1] && euler_stall);
	assign quat_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], quat_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_wx_s1 <= quat_w * quat_x;
			p_yz_s1 <= quat_y * quat_z;
			p_xx_s1 <= quat_x * quat_x;
			p_yy_s1 <= quat_y * quat_y;
			p_wz_s1 <= quat_w * quat_z;
			p_xy_s1 <= quat_x * quat_y;
			p_zz_s1 <= quat_z * quat_z;
			p_wy_s1 <= quat_w * quat_y;
			p_zx_s1 <= quat_z * quat_x;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sr_s2 <= (CW'(p_wx_s1) + CW'(p_yz_s1)) <<< 1;
			cr_s2 <= ONE - ((CW'(p_xx_s1) + CW'(p_yy_s1)) <<< 1);
			sy_s2 <= (CW'(p_wz_s1) + CW'(p_xy_s1)) <<< 1;
			cy_s2 <= ONE - ((CW'(p_yy_s1) + CW'(p_zz_s1)) <<< 1);
			s_s2  <= (CW'(p_wy_s1) - CW'(p_zx_s1)) <<< 1;
		end
	end

	assign a_mag = (s_s2 < 0) ? CW'(-s_s2) : CW'(s_s2);

	if (SH >= 0) begin : g_shr
		assign a30 = A_W'(a_mag >> SH);
	end else begin : g_shl
		assign a30 = A_W'(a_mag << (-SH));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flag_s3.clamp <= a_mag >= CW'(ONE);
			flag_s3.neg   <= s_s2 < 0;
			a30_s3        <= a30;
			sq_s4         <= a30_s3 * a30_s3;
			rad_s5        <= ONE_Q60 - SQ_W'(sq_s4);
			ad_q[0]       <= a30_s3;
			for (int i = 1; i < AD; i++) begin
				ad_q[i] <= ad_q[i-1];
			end
		end
	end

	assign sq_v[0] = rad_s5;
	assign sq_r[0] = '0;

	for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
		q2e_sqrt_cell #(.K(SQ_STAGES - 1 - j)) u_sqrt (
			.clk   (clk),
			.en    (en),
			.v     (sq_v[j]),
			.res   (sq_r[j]),
			.v_q   (sq_v[j+1]),
			.res_q (sq_r[j+1])
		);
	end

	assign px = signed'(PW'(sq_r[SQ_STAGES][A_W:0]));
	assign py = signed'(PW'(ad_q[AD-1]));

	q2e_cordic_chain #(.W(CW), .STAGES(CORDIC_STAGES), .LIM(ANGLE_LIM)) u_roll (
		.clk   (clk),
		.en    (en),
		.x_in  (cr_s2),
		.y_in  (sr_s2),
		.angle (roll_c)
	);

	q2e_cordic_chain #(.W(CW), .STAGES(CORDIC_STAGES), .LIM(ANGLE_LIM)) u_yaw (
		.clk   (clk),
		.en    (en),
		.x_in  (cy_s2),
		.y_in  (sy_s2),
		.angle (yaw_c)
	);

	q2e_cordic_chain #(.W(PW), .STAGES(CORDIC_STAGES), .LIM(PITCH_LIM)) u_pitch (
		.clk   (clk),
		.en    (en),
		.x_in  (px),
		.y_in  (py),
		.angle (pitch_c)
	);

	// Roll, yaw and the pitch flags wait here for the square root.
	always_ff @(posedge clk) begin
		if (en) begin
			roll_dly_q[0] <= roll_c;
			yaw_dly_q[0]  <= yaw_c;
			flag_dly_q[0] <= flag_s3;
			for (int i = 1; i < RD; i++) begin
				roll_dly_q[i] <= roll_dly_q[i-1];
				yaw_dly_q[i]  <= yaw_dly_q[i-1];
			end
			for (int i = 1; i < FD; i++) begin
				flag_dly_q[i] <= flag_dly_q[i-1];
			end
		end
	end

	always_comb begin
		if (flag_dly_q[FD-1].clamp) begin
			pitch_v = flag_dly_q[FD-1].neg ? 16'(-PITCH_LIM) : 16'(PITCH_LIM);
		end else begin
			pitch_v = flag_dly_q[FD-1].neg ? -pitch_c : pitch_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_q  <= roll_dly_q[RD-1];
			yaw_q   <= yaw_dly_q[RD-1];
			pitch_q <= 15'(pitch_v);
			clamp_q <= flag_dly_q[FD-1].clamp;
		end
	end

	assign euler_valid   = vld_q[LAT-1];
	assign roll_angle    = roll_q;
	assign yaw_angle     = yaw_q;
	assign pitch_angle   = pitch_q;
	assign pitch_clamped = clamp_q;

	`Q2E_ASSERT(a_clamp_pitch, euler_valid && pitch_clamped |-> (pitch_angle == 15'sd12868 || pitch_angle == -15'sd12868), "clamped pitch is not at the limit")
	`Q2E_ASSERT(a_roll_range, euler_valid |-> (roll_angle <= 16'sd25736 && roll_angle >= -16'sd25736), "roll out of range")
	`Q2E_ASSERT(a_hold_input, euler_valid && euler_stall |-> quat_stall, "input taken while the result is stalled")
	`Q2E_ASSERT(a_track_item, quat_valid && !quat_stall |=> vld_q[0], "accepted item lost at the first stage")

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for quaternion_to_euler_top: drives quaternions and checks roll, pitch and yaw.
// An internal fixed-point predictor supplies the expected angles.
// Depends on q2e_pkg and the RTL of quaternion_to_euler_top.
`timescale 1ns / 100ps

module testbench import q2e_pkg::*;;

	localparam int N_RANDOM = 1600;
	localparam int STAGES = 16;
	localparam int FRAC = 14;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 80;
	localparam longint ATAN_Q30 [24] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288,
		262144, 131072, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128};

	typedef struct {
		logic signed [15:0] w, x, y, z;
		bit pinned;                        // pitch and clamp typed in by hand
		logic signed [14:0] pitch;
		logic clamp;
	} quat_row_t;

	typedef struct {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
		logic clamp;
	} euler_t;

	logic clk, arst_n;
	logic quat_valid, quat_stall;
	logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
	logic euler_valid, euler_stall;
	logic signed [15:0] roll_angle, yaw_angle;
	logic signed [14:0] pitch_angle;
	logic pitch_clamped;

	quat_row_t quat_rows[$];
	euler_t pending_angles[$];
	int fed, checked, mismatches, clamp_seen, cycles;
	int sender_idle_pct, receiver_stall_pct;

	quaternion_to_euler_top dut (
		.clk, .arst_n, .quat_valid, .quat_stall, .quat_w, .quat_x, .quat_y, .quat_z,
		.euler_valid, .euler_stall, .roll_angle, .pitch_angle, .yaw_angle, .pitch_clamped
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint vector_angle(longint yv, longint xv);
		longint acc, t, dx, dy;
		acc = 0;
		if (xv == 0 && yv == 0)
			return 0;
		if (xv < 0) begin
			t = xv;
			if (yv >= 0) begin
				xv = yv; yv = -t; acc = longint'(HALF_PI_Q30);
			end else begin
				xv = -yv; yv = t; acc = -longint'(HALF_PI_Q30);
			end
		end
		for (int i = 0; i < STAGES; i++) begin
			dx = yv >>> i;
			dy = xv >>> i;
			if (yv >= 0) begin
				xv += dx; yv -= dy; acc += ATAN_Q30[i];
			end else begin
				xv -= dx; yv += dy; acc -= ATAN_Q30[i];
			end
		end
		return acc;
	endfunction

	function automatic longint q30_to_q13(longint a, longint lim);
		longint r;
		r = (a + 65536) >>> 17;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function automatic euler_t predict_angles(quat_row_t q);
		euler_t e;
		longint w, x, y, z, unity, sr, cr, sy, cy, s, mag, p;
		longint unsigned a30, c;
		w = q.w; x = q.x; y = q.y; z = q.z;
		unity = longint'(1) << (2 * FRAC);
		sr = 2 * (w * x + y * z);
		cr = unity - 2 * (x * x + y * y);
		sy = 2 * (w * z + x * y);
		cy = unity - 2 * (y * y + z * z);
		s = 2 * (w * y - z * x);
		mag = s < 0 ? -s : s;
		e.roll = 16'(q30_to_q13(vector_angle(sr, cr), ANGLE_LIM));
		e.yaw = 16'(q30_to_q13(vector_angle(sy, cy), ANGLE_LIM));
		if (mag >= unity) begin
			p = s < 0 ? -PITCH_LIM : PITCH_LIM;
			e.clamp = 1'b1;
		end else begin
			// Sine magnitude goes to Q.30 before the cosine is rebuilt from it.
			a30 = longint'(mag) << (30 - 2 * FRAC);
			if (a30 > (64'd1 << 30)) a30 = 64'd1 << 30;
			c = floor_sqrt((64'd1 << 60) - a30 * a30);
			p = q30_to_q13(vector_angle(longint'(a30), longint'(c)), PITCH_LIM);
			if (s < 0) p = -p;
			e.clamp = 1'b0;
		end
		e.pitch = 15'(p);
		return e;
	endfunction

	function automatic logic signed [15:0] pick_component(int kind);
		logic signed [15:0] corners [6] = '{16'sh0000, 16'sh4000, -16'sh4000,
			16'sh7fff, -16'sh8000, 16'sh0001};
		case (kind)
			0: return 16'($urandom);
			1: return corners[$urandom_range(0, 5)];
			default: return 16'($signed($urandom_range(0, 16384)) - 8192);
		endcase
	endfunction

	task automatic add_row(int w, int x, int y, int z, bit pinned = 0, int pitch = 0,
			bit clamp = 0);
		quat_row_t r;
		r.w = 16'(w); r.x = 16'(x); r.y = 16'(y); r.z = 16'(z);
		r.pinned = pinned; r.pitch = 15'(pitch); r.clamp = clamp;
		quat_rows.push_back(r);
	endtask

	task automatic set_idling(int item_no);
		case ((item_no / 200) % 4)
			0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
			1: begin sender_idle_pct = 73; receiver_stall_pct = 0; end
			2: begin sender_idle_pct = 0; receiver_stall_pct = 73; end
			default: begin sender_idle_pct = 31; receiver_stall_pct = 31; end
		endcase
	endtask

	initial begin
		int kind;
		// Directed table: identity, zero and non-unit quaternions, extremes, clamped pitch.
		add_row(16384, 0, 0, 0);
		add_row(0, 0, 0, 0);
		add_row(0, 16384, 0, 0);
		add_row(0, 0, 0, 16384);
		add_row(11585, 11585, 0, 0);
		add_row(11585, 0, 0, -11585);
		add_row(16384, 0, 16384, 0, 1, PITCH_LIM, 1);
		add_row(16384, 0, -16384, 0, 1, -PITCH_LIM, 1);
		add_row(0, 16384, 0, 16384, 1, -PITCH_LIM, 1);
		add_row(32767, 32767, 32767, 32767);
		add_row(-32768, -32768, -32768, -32768);
		add_row(32767, -32768, 32767, -32768);
		add_row(-32768, 32767, 32767, 32767);
		add_row(16383, 0, 5, 0);
		add_row(11585, 0, 11584, 0);
		add_row(-1, -1, -1, -1);
		add_row(1, 0, 0, 0);
		add_row(0, 0, 16384, 0);
		add_row(-16384, 0, 0, 0);
		add_row(0, -32768, 0, 0);
		for (int i = 0; i < N_RANDOM; i++) begin
			kind = $urandom_range(0, 9) < 3 ? 0 : ($urandom_range(0, 9) < 2 ? 1 : 2);
			add_row(pick_component(kind), pick_component(kind), pick_component(kind),
				pick_component(kind));
		end
	end

	// Reset and sender.
	initial begin
		quat_row_t cur;
		euler_t e;
		int gap;
		arst_n <= 1'b0;
		quat_valid <= 1'b0;
		quat_w <= '0; quat_x <= '0; quat_y <= '0; quat_z <= '0;
		euler_stall <= 1'b0;
		fed = 0;
		gap = 0;
		set_idling(0);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		forever begin
			@(posedge clk);
			if (quat_valid && !quat_stall) begin
				e = predict_angles(cur);
				if (cur.pinned) begin
					e.pitch = cur.pitch;
					e.clamp = cur.clamp;
				end
				pending_angles.push_back(e);
				fed++;
				set_idling(fed);
				if (fed % 200 == 0)
					gap = $urandom_range(0, 9) < 4 ? $urandom_range(1, 6) : 0;
			end
			if (quat_valid && quat_stall) begin
				// Payload holds while stalled.
			end else if (fed == quat_rows.size()) begin
				quat_valid <= 1'b0;
			end else if (fed == 900 && pending_angles.size() != 0) begin
				quat_valid <= 1'b0;     // let the pipeline drain completely once
			end else if (gap > 0 || $urandom_range(0, 99) < sender_idle_pct) begin
				if (gap > 0) gap--;
				quat_valid <= 1'b0;
			end else begin
				cur = quat_rows[fed];
				quat_w <= cur.w; quat_x <= cur.x; quat_y <= cur.y; quat_z <= cur.z;
				quat_valid <= 1'b1;
			end
		end
	end

	// Receiver: random stall plus result check.
	always @(posedge clk) begin
		euler_t e;
		if (arst_n) begin
			if (euler_valid && !euler_stall) begin
				if (pending_angles.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result item: roll %0d pitch %0d yaw %0d",
							roll_angle, pitch_angle, yaw_angle);
				end else begin
					e = pending_angles.pop_front();
					checked++;
					if (pitch_clamped) clamp_seen++;
					if (roll_angle !== e.roll || pitch_angle !== e.pitch
							|| yaw_angle !== e.yaw || pitch_clamped !== e.clamp) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("Mismatch on item %0d: expected roll %0d pitch %0d yaw %0d clamp %0b",
								checked - 1, e.roll, e.pitch, e.yaw, e.clamp);
							$display("  got roll %0d pitch %0d yaw %0d clamp %0b",
								roll_angle, pitch_angle, yaw_angle, pitch_clamped);
						end
					end
				end
			end
			euler_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d items still expected", cycles,
				pending_angles.size());
			$display("quaternion_to_euler_top verification failed");
			$finish;
		end
	end

	initial begin
		cycles = 0; checked = 0; mismatches = 0; clamp_seen = 0;
		@(posedge clk);
		while (!(quat_rows.size() > 0 && fed == quat_rows.size()
				&& pending_angles.size() == 0))
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_angles.size() != 0) mismatches += pending_angles.size();
		$display("Checked %0d quaternions (%0d with clamped pitch) under four idling mixes.",
			checked, clamp_seen);
		$display("Mismatches: %0d", mismatches);
		if (mismatches == 0)
			$display("quaternion_to_euler_top verification clean");
		else
			$display("quaternion_to_euler_top verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/q2e_pkg.sv
hdl/q2e_cordic_cell.sv
hdl/q2e_sqrt_cell.sv
hdl/q2e_cordic_chain.sv
hdl/quaternion_to_euler_top.sv
tb/sv/testbench.sv
